/* design/assert_macros.svh */
// Assertion macros shared by the RTL. Both use the clock clk and the
// active-low reset arst_n of the module that includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property checked at every rising clock edge outside reset.
`define OLI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// A condition that must never hold outside reset.
`define OLI_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition");

`else

`define OLI_ASSERT(lbl, prop)
`define OLI_NEVER(lbl, expr)

`endif

`endif

/* design/olist_pkg.sv */
`default_nettype none

package olist_pkg;

	// List geometry.
	localparam int DEPTH  = 256;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	// The search reduction works on groups of cells.
	localparam int GRP    = 16;
	localparam int GRP_W  = 4;
	localparam int NGRP   = DEPTH / GRP;
	localparam int NGRP_W = IDX_W - GRP_W;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_READ   = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_SEARCH = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_GRP,
		S_SEL,
		S_DONE
	} state_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              locate;
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] key;
	} cell_ctl_t;

	// First matching cell as found by the reduction.
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
	} sel_t;

endpackage

`default_nettype wire

/* design/olist_cell.sv */
`default_nettype none

module olist_cell (
	input  wire logic                          clk,
	input  wire olist_pkg::cell_ctl_t          ctl,
	input  wire logic [olist_pkg::IDX_W-1:0]   idx,
	input  wire logic [olist_pkg::DATA_W-1:0]  left,
	input  wire logic [olist_pkg::DATA_W-1:0]  right,
	output logic      [olist_pkg::DATA_W-1:0]  entry_q,
	output logic                               hit_q
);

	// Entry update: take the lower neighbor on insert, the upper one on delete.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx > ctl.pos) begin
				entry_q <= left;
			end else if (idx == ctl.pos) begin
				entry_q <= ctl.key;
			end
		end else if (ctl.del) begin
			if (idx >= ctl.pos) begin
				entry_q <= right;
			end
		end
	end

	// Match flag: either this cell is the addressed one, or it holds the key.
	always_ff @(posedge clk) begin
		if (ctl.locate) begin
			hit_q <= (idx == ctl.pos);
		end else begin
			hit_q <= ({1'b0, idx} < ctl.cnt) && (entry_q == ctl.key);
		end
	end

endmodule

`default_nettype wire

/* design/olist_reduce.sv */
`default_nettype none

module olist_reduce (
	input  wire logic                                            clk,
	input  wire logic [olist_pkg::DEPTH-1:0]                     hit,
	input  wire logic [olist_pkg::DEPTH-1:0][olist_pkg::DATA_W-1:0] ent,
	output olist_pkg::sel_t                                      sel_s2
);

	logic [olist_pkg::GRP-1:0][olist_pkg::DATA_W-1:0] grp_ent [olist_pkg::NGRP];
	logic [olist_pkg::GRP-1:0]   grp_hit [olist_pkg::NGRP];
	logic [olist_pkg::GRP_W-1:0] grp_idx [olist_pkg::NGRP];

	logic [olist_pkg::NGRP-1:0]  any_s1;
	logic [olist_pkg::GRP_W-1:0] idx_s1 [olist_pkg::NGRP];
	logic [olist_pkg::DATA_W-1:0] val_s1 [olist_pkg::NGRP];

	logic [olist_pkg::NGRP_W-1:0] top_idx;

	// First stage: lowest hit inside each group of cells.
	always_comb begin
		for (int g = 0; g < olist_pkg::NGRP; g++) begin
			grp_ent[g] = ent[g*olist_pkg::GRP +: olist_pkg::GRP];
			grp_hit[g] = hit[g*olist_pkg::GRP +: olist_pkg::GRP];
			grp_idx[g] = '0;
			for (int j = olist_pkg::GRP - 1; j >= 0; j--) begin
				if (grp_hit[g][j]) begin
					grp_idx[g] = olist_pkg::GRP_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < olist_pkg::NGRP; g++) begin
			any_s1[g] <= |grp_hit[g];
			idx_s1[g] <= grp_idx[g];
			val_s1[g] <= grp_ent[g][grp_idx[g]];
		end
	end

	// Second stage: lowest group that has a hit.
	always_comb begin
		top_idx = '0;
		for (int g = olist_pkg::NGRP - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				top_idx = olist_pkg::NGRP_W'(g);
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_s2.hit <= |any_s1;
		sel_s2.idx <= {top_idx, idx_s1[top_idx]};
		sel_s2.val <= val_s1[top_idx];
	end

endmodule

`default_nettype wire

/* design/ordered_list_insert_delete_search.sv */
// Channel   Handshake             Payload
// request   req_valid/req_stall   action, position, value
// response  rsp_valid/rsp_stall   status, result_value, found_position, entry_count
//
// After its transfer every request steps through CMP, GRP, SEL and DONE before
// the block takes the next one; the steps follow the registered match flags of
// the cell row and the two registered stages of the first-match reduction that
// follow it. A response waiting in the output register holds the last step only.
// Reset clears the count, the sequencer and the response valid; the entries
// themselves carry no reset and are read only below the count.
`default_nettype none

module ordered_list_insert_delete_search (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [2:0]          action,
	input  wire logic [7:0]          position,
	input  wire logic signed [31:0]  value,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [1:0]               status,
	output logic signed [31:0]       result_value,
	output logic [7:0]               found_position,
	output logic [8:0]               entry_count
);

	`include "assert_macros.svh"

	olist_pkg::state_t state_q, state_d;

	logic                           req_xfer;
	logic                           advance;
	olist_pkg::action_t             act_q;
	logic [olist_pkg::IDX_W-1:0]    pos_q;
	logic [olist_pkg::DATA_W-1:0]   key_q;
	logic [olist_pkg::CNT_W-1:0]    cnt_q, cnt_d;

	olist_pkg::cell_ctl_t           ctl;
	logic [olist_pkg::DEPTH-1:0]    hit;
	logic [olist_pkg::DEPTH-1:0][olist_pkg::DATA_W-1:0] ent;
	olist_pkg::sel_t                sel_s2;

	olist_pkg::status_t             status_d, status_q;
	logic [olist_pkg::DATA_W-1:0]   rval_d, rval_q;
	logic [olist_pkg::IDX_W-1:0]    fpos_d, fpos_q;
	logic                           do_ins, do_del;
	logic                           rsp_valid_q;

	// Request transfer and sequencer advance.
	assign req_stall = (state_q != olist_pkg::S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign advance   = (state_q == olist_pkg::S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olist_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			olist_pkg::S_IDLE: if (req_xfer) state_d = olist_pkg::S_CMP;
			olist_pkg::S_CMP:  state_d = olist_pkg::S_GRP;
			olist_pkg::S_GRP:  state_d = olist_pkg::S_SEL;
			olist_pkg::S_SEL:  state_d = olist_pkg::S_DONE;
			olist_pkg::S_DONE: if (advance) state_d = olist_pkg::S_IDLE;
			default:           state_d = olist_pkg::S_IDLE;
		endcase
	end

	// Captured request.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			act_q <= olist_pkg::action_t'(action);
			pos_q <= position;
			key_q <= value;
		end
	end

	// Outcome of the request, evaluated once the reduction has settled.
	always_comb begin
		status_d = olist_pkg::ST_OK;
		rval_d   = '0;
		fpos_d   = '0;
		cnt_d    = cnt_q;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		case (act_q)
			olist_pkg::ACT_CLEAR: begin
				cnt_d = '0;
			end
			olist_pkg::ACT_APPEND: begin
				if (cnt_q == olist_pkg::DEPTH_CNT) begin
					status_d = olist_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			olist_pkg::ACT_READ: begin
				if ({1'b0, pos_q} >= cnt_q) begin
					status_d = olist_pkg::ST_RANGE;
				end else begin
					rval_d = sel_s2.val;
				end
			end
			olist_pkg::ACT_INSERT: begin
				if (cnt_q == olist_pkg::DEPTH_CNT) begin
					status_d = olist_pkg::ST_FULL;
				end else if ({1'b0, pos_q} > cnt_q) begin
					status_d = olist_pkg::ST_RANGE;
				end else begin
					do_ins = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			olist_pkg::ACT_DELETE: begin
				if ({1'b0, pos_q} >= cnt_q) begin
					status_d = olist_pkg::ST_RANGE;
				end else begin
					rval_d = sel_s2.val;
					do_del = 1'b1;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			olist_pkg::ACT_SEARCH: begin
				if (sel_s2.hit) begin
					fpos_d = sel_s2.idx;
				end else begin
					status_d = olist_pkg::ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	// Control broadcast to the cell row; an append inserts at the count.
	always_comb begin
		ctl.ins    = advance && do_ins;
		ctl.del    = advance && do_del;
		ctl.locate = (act_q != olist_pkg::ACT_SEARCH);
		ctl.pos    = (act_q == olist_pkg::ACT_APPEND) ? cnt_q[olist_pkg::IDX_W-1:0] : pos_q;
		ctl.cnt    = cnt_q;
		ctl.key    = key_q;
	end

	// The row of cells, each linked to its two neighbors.
	for (genvar i = 0; i < olist_pkg::DEPTH; i++) begin : g_cell
		localparam bit [31:0] CI = i;
		logic [olist_pkg::DATA_W-1:0] left_w, right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_lo
			assign left_w = ent[i-1];
		end

		if (i == olist_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_hi
			assign right_w = ent[i+1];
		end

		olist_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.idx     (CI[olist_pkg::IDX_W-1:0]),
			.left    (left_w),
			.right   (right_w),
			.entry_q (ent[i]),
			.hit_q   (hit[i])
		);
	end

	// First-match reduction over the cell flags.
	olist_reduce u_reduce (
		.clk    (clk),
		.hit    (hit),
		.ent    (ent),
		.sel_s2 (sel_s2)
	);

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_d;
		end
	end

	// Response register; it is loaded when the previous response has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			rval_q   <= rval_d;
			fpos_q   <= fpos_d;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign result_value   = rval_q;
	assign found_position = fpos_q;
	assign entry_count    = cnt_q;

	// A new response only follows the final step of the sequencer.
	`OLI_ASSERT(a_rsp_from_done, $rose(rsp_valid_q) |-> $past(state_q == olist_pkg::S_DONE))
	// The count moves by at most one unless the list is cleared.
	`OLI_ASSERT(a_cnt_step, (advance && act_q != olist_pkg::ACT_CLEAR) |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1))
	// A rejected request leaves the count alone.
	`OLI_ASSERT(a_reject_keeps_cnt, (advance && (status_d == olist_pkg::ST_FULL || status_d == olist_pkg::ST_RANGE)) |=> (cnt_q == $past(cnt_q)))
	// The count never passes the list depth.
	`OLI_NEVER(a_cnt_bound, cnt_q > olist_pkg::DEPTH_CNT)

endmodule

`default_nettype wire
